### hdl/slc_pkg.sv
// Shared types, codes and constants for the shift light LED bar controller.
// No dependencies; used by slc_front, slc_back and the top level through scoped names.
package slc_pkg;

  localparam int TIME_W   = 32;
  localparam int RPM_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CMD_W    = 3;
  localparam int GS_W     = 3;
  localparam int GEAR_W   = 5;
  localparam int CFG_IDX_W = 2;

  // 20*rpm and 17*max_rpm both fit in 21 bits; 6*max_rpm fits in 19.
  localparam int DIFF_W = 21;
  localparam int DEN_W  = 19;

  localparam int MAX_CMDS  = 5;
  localparam int CMD_IDX_W = 3;

  localparam int NUM_LEDS_DEF     = 12;
  localparam int ITEM_Q_DEPTH_DEF = 2;
  localparam int OUT_Q_DEPTH_DEF  = 4;

  localparam logic [CFG_W-1:0] BLINK_DELAY_RST  = 16'd250;
  localparam logic [CFG_W-1:0] NEUTRAL_DELAY_RST = 16'd3000;
  localparam logic [CFG_W-1:0] TACH_PERIOD_RST  = 16'd100;
  localparam logic [CFG_W-1:0] ENGINE_THR_RST   = 16'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_LED     = 3'd1,
    CMD_BLINK   = 3'd2,
    CMD_NEUTRAL = 3'd3,
    CMD_ANIM    = 3'd4,
    CMD_TACH    = 3'd5
  } cmd_t;

  typedef enum logic [GS_W-1:0] {
    GS_EXITED    = 3'd0,
    GS_FRONT_END = 3'd1,
    GS_PLAYING   = 3'd2,
    GS_PAUSED    = 3'd3
  } game_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLINK_DELAY   = 2'd0,
    REG_NEUTRAL_DELAY = 2'd1,
    REG_TACH_PERIOD   = 2'd2,
    REG_ENGINE_THR    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_OFF   = 2'd0,
    PH_ARMED = 2'd1,
    PH_ON    = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0] blink_delay_ms;
    logic [CFG_W-1:0] neutral_delay_ms;
    logic [CFG_W-1:0] tach_period_ms;
    logic [CFG_W-1:0] engine_rpm_threshold;
  } cfg_t;

  // One classified sample as it sits in the queue between front and back.
  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic [RPM_W-1:0]  rpm;
    logic [RPM_W-1:0]  max_rpm;
    logic [DIFF_W-1:0] diff;       // 20*rpm - 17*max_rpm, meaningful when led_gt
    logic              is_menu;    // exited, front end or paused
    logic              is_play;
    logic              gear_zero;
    logic              throttle;
    logic              led_gt;     // 20*rpm > 17*max_rpm
    logic              mx_zero;
    logic              eng_on;
  } item_t;

  typedef struct packed {
    cmd_t             command;
    logic [RPM_W-1:0] value;
    logic             last;
  } result_t;

endpackage

### hdl/slc_fifo.sv
// Small register queue with count-based full/empty flags.
// Depends on nothing; used for the sample queue and the result queue.
module slc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

### hdl/slc_front.sv
// Front end: classifies one telemetry sample into a queue entry.
// Depends on slc_pkg (item_t, game state codes).
module slc_front (
  input  logic [slc_pkg::TIME_W-1:0]        now_ms,
  input  logic [slc_pkg::GS_W-1:0]          game_state,
  input  logic [slc_pkg::RPM_W-1:0]         rpm,
  input  logic [slc_pkg::RPM_W-1:0]         max_rpm,
  input  logic signed [slc_pkg::GEAR_W-1:0] gear,
  input  logic                              throttle_nonzero,
  input  logic [slc_pkg::CFG_W-1:0]         eng_threshold,
  output slc_pkg::item_t                    item
);

  logic [slc_pkg::DIFF_W-1:0] rpm_x20;
  logic [slc_pkg::DIFF_W-1:0] max_x17;

  assign rpm_x20 = slc_pkg::DIFF_W'(rpm) * slc_pkg::DIFF_W'(20);
  assign max_x17 = slc_pkg::DIFF_W'(max_rpm) * slc_pkg::DIFF_W'(17);

  always_comb begin
    item.now_ms    = now_ms;
    item.rpm       = rpm;
    item.max_rpm   = max_rpm;
    item.diff      = rpm_x20 - max_x17;
    item.is_menu   = (game_state == slc_pkg::GS_EXITED) ||
                     (game_state == slc_pkg::GS_FRONT_END) ||
                     (game_state == slc_pkg::GS_PAUSED);
    item.is_play   = (game_state == slc_pkg::GS_PLAYING);
    item.gear_zero = (gear == '0);
    item.throttle  = throttle_nonzero;
    item.led_gt    = (rpm_x20 > max_x17);
    item.mx_zero   = (max_rpm == '0);
    item.eng_on    = (rpm > eng_threshold);
  end

endmodule

### hdl/slc_back.sv
// Back end: restoring divider for the LED count, panel state update and
// command sequencing into the result queue. Depends on slc_pkg.
module slc_back #(
  parameter int NUM_LEDS = slc_pkg::NUM_LEDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  slc_pkg::item_t   q_item,
  output logic             q_pop,
  input  slc_pkg::cfg_t    cfg,
  input  logic             out_full,
  output logic             out_push,
  output slc_pkg::result_t out_res
);

  localparam int LED_W  = $clog2(NUM_LEDS + 1);
  localparam int QB     = LED_W;
  localparam int Q_W    = QB + 1;
  localparam int STEP_W = $clog2(QB + 1);
  localparam int NUM_W  = slc_pkg::DIFF_W + $clog2(2 * NUM_LEDS) + 1;
  localparam int CMP_W  = (NUM_W > slc_pkg::DEN_W + QB) ? NUM_W : slc_pkg::DEN_W + QB;
  localparam logic [LED_W-1:0] FULL_BAR = LED_W'(NUM_LEDS);
  localparam int CI_W = slc_pkg::CMD_IDX_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_EXEC = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  function automatic slc_pkg::result_t mk_res(slc_pkg::cmd_t cmd,
                                              logic [slc_pkg::RPM_W-1:0] val);
    slc_pkg::result_t r;
    r.command = cmd;
    r.value   = val;
    r.last    = 1'b0;
    return r;
  endfunction

  state_t state_r, state_nxt;
  slc_pkg::item_t item_r;

  logic [CMP_W-1:0]  rem_r, dsh_r;
  logic [Q_W-1:0]    q_r;
  logic [STEP_W-1:0] step_r;
  logic [NUM_W-1:0]  num_w;
  logic [slc_pkg::DEN_W-1:0] den_w;
  logic              ge_w;

  logic                        anim_on_r;
  logic [LED_W-1:0]            prev_led_r;
  slc_pkg::phase_t             blink_ph_r, neut_ph_r;
  logic [slc_pkg::TIME_W-1:0]  blink_start_r, neut_start_r, tach_time_r;
  logic                        prev_eng_r;
  logic [slc_pkg::RPM_W-1:0]   tach_rpm_r;

  slc_pkg::result_t list_r [slc_pkg::MAX_CMDS];
  logic [CI_W-1:0]  cnt_r, idx_r;

  // EXEC-cycle next values
  logic                        anim_nxt, eng_nxt;
  logic [LED_W-1:0]            led_nxt, n_w;
  slc_pkg::phase_t             blink_ph_nxt, neut_ph_nxt;
  logic [slc_pkg::TIME_W-1:0]  blink_start_nxt, neut_start_nxt, tach_time_nxt;
  logic [slc_pkg::RPM_W-1:0]   tach_rpm_nxt;
  slc_pkg::result_t            list_nxt [slc_pkg::MAX_CMDS];
  logic [CI_W-1:0]             cnt_nxt;
  logic                        blink_gt, neut_gt, tach_gt;
  logic                        emit_last, emit_go;

  assign q_pop = (state_r == ST_IDLE) && !q_empty;

  // numerator 2N*(20r-17m) + 3m, denominator 6m
  assign num_w = NUM_W'(2 * NUM_LEDS) * NUM_W'(q_item.diff) +
                 NUM_W'(q_item.max_rpm) * NUM_W'(3);
  assign den_w = slc_pkg::DEN_W'(q_item.max_rpm) * slc_pkg::DEN_W'(6);
  assign ge_w  = (rem_r >= dsh_r);

  // quotient top bit set means the count is past the bar anyway
  always_comb begin
    if (!item_r.led_gt) begin
      n_w = '0;
    end else if (item_r.mx_zero || (q_r > Q_W'(NUM_LEDS))) begin
      n_w = FULL_BAR;
    end else begin
      n_w = q_r[LED_W-1:0];
    end
  end

  assign blink_gt = (item_r.now_ms - blink_start_r) >
                    slc_pkg::TIME_W'(cfg.blink_delay_ms);
  assign neut_gt  = (item_r.now_ms - neut_start_r) >
                    slc_pkg::TIME_W'(cfg.neutral_delay_ms);
  assign tach_gt  = (item_r.now_ms - tach_time_r) >
                    slc_pkg::TIME_W'(cfg.tach_period_ms);

  always_comb begin
    logic b_arm;
    logic n_arm;
    anim_nxt        = anim_on_r;
    led_nxt         = prev_led_r;
    blink_ph_nxt    = blink_ph_r;
    blink_start_nxt = blink_start_r;
    neut_ph_nxt     = neut_ph_r;
    neut_start_nxt  = neut_start_r;
    eng_nxt         = prev_eng_r;
    tach_time_nxt   = tach_time_r;
    tach_rpm_nxt    = tach_rpm_r;
    cnt_nxt         = '0;
    b_arm           = 1'b0;
    n_arm           = 1'b0;
    for (int i = 0; i < slc_pkg::MAX_CMDS; i++) begin
      list_nxt[i] = mk_res(slc_pkg::CMD_LED, '0);
    end

    if (!anim_on_r && item_r.is_menu) begin
      list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_ANIM, slc_pkg::RPM_W'(1));
      cnt_nxt = cnt_nxt + CI_W'(1);
      anim_nxt = 1'b1;
    end else if (item_r.is_play) begin
      if (anim_on_r) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_ANIM, '0);
        cnt_nxt = cnt_nxt + CI_W'(1);
        anim_nxt = 1'b0;
      end
      if (prev_led_r != n_w) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_LED, slc_pkg::RPM_W'(n_w));
        cnt_nxt = cnt_nxt + CI_W'(1);
        blink_ph_nxt = slc_pkg::PH_OFF;
        neut_ph_nxt  = slc_pkg::PH_OFF;
      end
      if (blink_ph_nxt == slc_pkg::PH_OFF && n_w == FULL_BAR) begin
        blink_start_nxt = item_r.now_ms;
        blink_ph_nxt    = slc_pkg::PH_ARMED;
        b_arm           = 1'b1;
      end
      // freshly armed timer has zero elapsed time
      if (blink_ph_nxt == slc_pkg::PH_ARMED && !b_arm && blink_gt) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_BLINK, slc_pkg::RPM_W'(1));
        cnt_nxt = cnt_nxt + CI_W'(1);
        blink_ph_nxt = slc_pkg::PH_ON;
      end
      if (prev_eng_r != item_r.eng_on) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_NEUTRAL,
                                   slc_pkg::RPM_W'(item_r.eng_on));
        cnt_nxt = cnt_nxt + CI_W'(1);
        neut_ph_nxt = item_r.eng_on ? slc_pkg::PH_ON : slc_pkg::PH_OFF;
      end
      if (item_r.eng_on && neut_ph_nxt == slc_pkg::PH_OFF && item_r.gear_zero &&
          n_w == '0 && !item_r.throttle) begin
        neut_start_nxt = item_r.now_ms;
        neut_ph_nxt    = slc_pkg::PH_ARMED;
        n_arm          = 1'b1;
      end
      if (neut_ph_nxt == slc_pkg::PH_ON && (!item_r.gear_zero || n_w != '0 ||
          item_r.throttle || !item_r.eng_on)) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_NEUTRAL, '0);
        cnt_nxt = cnt_nxt + CI_W'(1);
        neut_ph_nxt = slc_pkg::PH_OFF;
      end else if (neut_ph_nxt == slc_pkg::PH_ARMED && !n_arm && neut_gt) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_NEUTRAL, slc_pkg::RPM_W'(1));
        cnt_nxt = cnt_nxt + CI_W'(1);
        neut_ph_nxt = slc_pkg::PH_ON;
      end
      led_nxt = n_w;
      eng_nxt = item_r.eng_on;
    end

    // tach check runs in every game state
    if (tach_gt) begin
      tach_time_nxt = item_r.now_ms;
      if (tach_rpm_r != item_r.rpm) begin
        list_nxt[cnt_nxt] = mk_res(slc_pkg::CMD_TACH, item_r.rpm);
        cnt_nxt = cnt_nxt + CI_W'(1);
      end
      tach_rpm_nxt = item_r.rpm;
    end
  end

  assign emit_last = (idx_r == cnt_r - CI_W'(1));
  assign out_push  = (state_r == ST_EMIT);
  assign emit_go   = out_push && !out_full;

  always_comb begin
    out_res      = list_r[idx_r];
    out_res.last = emit_last;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (!q_empty) state_nxt = ST_DIV;
      ST_DIV:  if (step_r == '0) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = (cnt_nxt == '0) ? ST_IDLE : ST_EMIT;
      ST_EMIT: if (emit_go && emit_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      anim_on_r     <= 1'b0;
      prev_led_r    <= '0;
      blink_ph_r    <= slc_pkg::PH_OFF;
      blink_start_r <= '0;
      neut_ph_r     <= slc_pkg::PH_OFF;
      neut_start_r  <= '0;
      prev_eng_r    <= 1'b0;
      tach_time_r   <= '0;
      tach_rpm_r    <= '0;
      cnt_r         <= '0;
      idx_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_EXEC) begin
        anim_on_r     <= anim_nxt;
        prev_led_r    <= led_nxt;
        blink_ph_r    <= blink_ph_nxt;
        blink_start_r <= blink_start_nxt;
        neut_ph_r     <= neut_ph_nxt;
        neut_start_r  <= neut_start_nxt;
        prev_eng_r    <= eng_nxt;
        tach_time_r   <= tach_time_nxt;
        tach_rpm_r    <= tach_rpm_nxt;
        cnt_r         <= cnt_nxt;
        idx_r         <= '0;
      end else if (emit_go) begin
        idx_r <= idx_r + CI_W'(1);
      end
    end
  end

  // payload: sample, divider datapath, command list
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item_r <= q_item;
      rem_r  <= CMP_W'(num_w);
      dsh_r  <= CMP_W'(den_w) << QB;
      q_r    <= '0;
      step_r <= STEP_W'(QB);
    end else if (state_r == ST_DIV) begin
      rem_r  <= ge_w ? rem_r - dsh_r : rem_r;
      dsh_r  <= dsh_r >> 1;
      q_r    <= {q_r[QB-1:0], ge_w};
      step_r <= step_r - STEP_W'(1);
    end
    if (state_r == ST_EXEC) begin
      for (int i = 0; i < slc_pkg::MAX_CMDS; i++) begin
        list_r[i] <= list_nxt[i];
      end
    end
  end

endmodule

### hdl/shift_light_led_bar_controller_unit.sv
// Shift light LED bar controller, top level: config registers, front end,
// sample queue, back end and result queue. Depends on slc_pkg and all slc_* modules.
// Flow: a popped sample passes the serial divider (LED bits), the state update and the
//   result queue write; the next sample is popped only once its last command is written.
// Commands are written 1 cmd/cycle, stalling while the result queue is full.
// Reset (rst_n low, synchronous): queues empty, panel state cleared, registers to defaults.
module shift_light_led_bar_controller_unit #(
  parameter int NUM_LEDS     = slc_pkg::NUM_LEDS_DEF,
  parameter int ITEM_Q_DEPTH = slc_pkg::ITEM_Q_DEPTH_DEF,
  parameter int OUT_Q_DEPTH  = slc_pkg::OUT_Q_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample input queue side
  input  logic                              in_push,
  output logic                              in_full,
  input  logic [slc_pkg::TIME_W-1:0]        in_now_ms,
  input  logic [slc_pkg::GS_W-1:0]          in_game_state,
  input  logic [slc_pkg::RPM_W-1:0]         in_rpm,
  input  logic [slc_pkg::RPM_W-1:0]         in_max_rpm,
  input  logic signed [slc_pkg::GEAR_W-1:0] in_gear,
  input  logic                              in_throttle_nonzero,
  // command output queue side
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic [slc_pkg::CMD_W-1:0]         out_command,
  output logic [slc_pkg::RPM_W-1:0]         out_value,
  output logic                              out_last,
  // config write port
  input  logic                              cfg_wr_en,
  input  logic [slc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [slc_pkg::CFG_W-1:0]         cfg_data
);

  localparam int ITEM_W = $bits(slc_pkg::item_t);
  localparam int RES_W  = $bits(slc_pkg::result_t);

  slc_pkg::cfg_t    cfg_r;
  slc_pkg::item_t   front_item, q_item;
  slc_pkg::result_t back_res, out_res;
  logic [ITEM_W-1:0] q_rdata;
  logic [RES_W-1:0]  out_rdata;
  logic              q_empty, q_pop;
  logic              res_full, res_push;

  // Config registers. The user writes them only while the block is idle (the block does
  // not enforce this), so the front and back read them directly with no shadowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.blink_delay_ms       <= slc_pkg::BLINK_DELAY_RST;
      cfg_r.neutral_delay_ms     <= slc_pkg::NEUTRAL_DELAY_RST;
      cfg_r.tach_period_ms       <= slc_pkg::TACH_PERIOD_RST;
      cfg_r.engine_rpm_threshold <= slc_pkg::ENGINE_THR_RST;
    end else if (cfg_wr_en) begin
      unique case (slc_pkg::reg_idx_t'(cfg_index))
        slc_pkg::REG_BLINK_DELAY:   cfg_r.blink_delay_ms       <= cfg_data;
        slc_pkg::REG_NEUTRAL_DELAY: cfg_r.neutral_delay_ms     <= cfg_data;
        slc_pkg::REG_TACH_PERIOD:   cfg_r.tach_period_ms       <= cfg_data;
        slc_pkg::REG_ENGINE_THR:    cfg_r.engine_rpm_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front: classify the sample (play/menu, 20*rpm vs 17*max, engine on)
  slc_front u_front (
    .now_ms           (in_now_ms),
    .game_state       (in_game_state),
    .rpm              (in_rpm),
    .max_rpm          (in_max_rpm),
    .gear             (in_gear),
    .throttle_nonzero (in_throttle_nonzero),
    .eng_threshold    (cfg_r.engine_rpm_threshold),
    .item             (front_item)
  );

  // Sample queue decouples the input beat from the back end's divider work.
  slc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign q_item = slc_pkg::item_t'(q_rdata);

  // Back: LED count division, panel state update, command sequencing
  slc_back #(
    .NUM_LEDS (NUM_LEDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg      (cfg_r),
    .out_full (res_full),
    .out_push (res_push),
    .out_res  (back_res)
  );

  // Result queue: the head entry drives the out_* ports while not empty.
  slc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_res     = slc_pkg::result_t'(out_rdata);
  assign out_command = out_res.command;
  assign out_value   = out_res.value;
  assign out_last    = out_res.last;

endmodule
